// ----- sv/hsv_tcp_pkg.sv -----
// ---------------------------------------------------------------------------
// hsv_tcp_pkg
// shared types, register codes and constants of the hsv threshold column peak
// block
// ---------------------------------------------------------------------------
`default_nettype none

package hsv_tcp_pkg;

   // default geometry limits, handed to the top level parameters
   localparam int DEF_MAX_COLS    = 1024;
   localparam int DEF_MAX_ROWS    = 1024;
   localparam int DEF_QUEUE_DEPTH = 4;

   // fixed field widths
   localparam int CHAN_W        = 8;
   localparam int GEOM_W        = 11;
   localparam int CSR_DATA_W    = 11;
   localparam int CSR_ADDR_W    = 3;
   localparam int PEAK_COLUMN_W = 10;
   localparam int PEAK_COUNT_W  = 11;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_HUE_LOW      = 3'd0,
      CSR_HUE_HIGH     = 3'd1,
      CSR_SAT_LOW      = 3'd2,
      CSR_SAT_HIGH     = 3'd3,
      CSR_VAL_LOW      = 3'd4,
      CSR_VAL_HIGH     = 3'd5,
      CSR_FRAME_WIDTH  = 3'd6,
      CSR_FRAME_HEIGHT = 3'd7
   } csr_index_type;

   // register reset values
   localparam logic [CHAN_W-1:0] RST_HUE_LOW      = 8'd0;
   localparam logic [CHAN_W-1:0] RST_HUE_HIGH     = 8'd180;
   localparam logic [CHAN_W-1:0] RST_SAT_LOW      = 8'd0;
   localparam logic [CHAN_W-1:0] RST_SAT_HIGH     = 8'd255;
   localparam logic [CHAN_W-1:0] RST_VAL_LOW      = 8'd0;
   localparam logic [CHAN_W-1:0] RST_VAL_HIGH     = 8'd255;
   localparam logic [GEOM_W-1:0] RST_FRAME_WIDTH  = 11'd640;
   localparam logic [GEOM_W-1:0] RST_FRAME_HEIGHT = 11'd480;

   typedef struct packed {
      logic [CHAN_W-1:0] hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } pixel_type;

   typedef struct packed {
      logic                     mask_bit;
      logic                     frame_done;
      logic [PEAK_COLUMN_W-1:0] peak_column;
      logic [PEAK_COUNT_W-1:0]  peak_count;
   } result_type;

   // classification of one pixel, front to back
   typedef struct packed {
      logic pass;
      logic first_row;
      logic last_row;
      logic row_end;
   } item_flags_type;

endpackage

`default_nettype wire

// ----- sv/hsv_tcp_front.sv -----
// ---------------------------------------------------------------------------
// hsv_tcp_front
// register file, range test and raster position tracking
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_tcp_front #(
   parameter int MAX_COLS = hsv_tcp_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = hsv_tcp_pkg::DEF_MAX_ROWS,
   parameter int COL_W    = $clog2(MAX_COLS)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [hsv_tcp_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [hsv_tcp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire hsv_tcp_pkg::pixel_type              req_data,
   input  wire logic                                q_full,
   output logic                                     q_push,
   output hsv_tcp_pkg::item_flags_type              q_push_flags,
   output logic [COL_W-1:0]                         q_push_col
);
   import hsv_tcp_pkg::*;

   localparam int ROW_W = $clog2(MAX_ROWS);

   logic [CHAN_W-1:0] hue_low_ff, hue_high_ff, sat_low_ff, sat_high_ff;
   logic [CHAN_W-1:0] val_low_ff, val_high_ff;
   logic [GEOM_W-1:0] width_ff, height_ff;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] last_col;
   logic [ROW_W-1:0] last_row_idx;
   logic             accept;
   item_flags_type   flags;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff  <= RST_HUE_LOW;
         hue_high_ff <= RST_HUE_HIGH;
         sat_low_ff  <= RST_SAT_LOW;
         sat_high_ff <= RST_SAT_HIGH;
         val_low_ff  <= RST_VAL_LOW;
         val_high_ff <= RST_VAL_HIGH;
         width_ff    <= RST_FRAME_WIDTH;
         height_ff   <= RST_FRAME_HEIGHT;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_addr))
            CSR_HUE_LOW:      hue_low_ff  <= csr_wdata[CHAN_W-1:0];
            CSR_HUE_HIGH:     hue_high_ff <= csr_wdata[CHAN_W-1:0];
            CSR_SAT_LOW:      sat_low_ff  <= csr_wdata[CHAN_W-1:0];
            CSR_SAT_HIGH:     sat_high_ff <= csr_wdata[CHAN_W-1:0];
            CSR_VAL_LOW:      val_low_ff  <= csr_wdata[CHAN_W-1:0];
            CSR_VAL_HIGH:     val_high_ff <= csr_wdata[CHAN_W-1:0];
            CSR_FRAME_WIDTH:  width_ff    <= csr_wdata[GEOM_W-1:0];
            CSR_FRAME_HEIGHT: height_ff   <= csr_wdata[GEOM_W-1:0];
            default: ;
         endcase
      end
   end

   // last usable column and row after clamping the geometry
   always_comb begin
      if (width_ff == '0) begin
         last_col = '0;
      end else if (int'(width_ff) > MAX_COLS) begin
         last_col = COL_W'(MAX_COLS - 1);
      end else begin
         last_col = COL_W'(width_ff - GEOM_W'(1));
      end
      if (height_ff == '0) begin
         last_row_idx = '0;
      end else if (int'(height_ff) > MAX_ROWS) begin
         last_row_idx = ROW_W'(MAX_ROWS - 1);
      end else begin
         last_row_idx = ROW_W'(height_ff - GEOM_W'(1));
      end
   end

   always_comb begin
      flags.pass      = (req_data.hue >= hue_low_ff) && (req_data.hue <= hue_high_ff) &&
                        (req_data.saturation >= sat_low_ff) &&
                        (req_data.saturation <= sat_high_ff) &&
                        (req_data.brightness >= val_low_ff) &&
                        (req_data.brightness <= val_high_ff);
      flags.first_row = (row_ff == '0);
      flags.last_row  = (row_ff >= last_row_idx);
      flags.row_end   = (col_ff >= last_col);
   end

   assign req_stall    = q_full;
   assign accept       = req_valid && !q_full;
   assign q_push       = accept;
   assign q_push_flags = flags;
   assign q_push_col   = col_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (flags.row_end) begin
            col_in = '0;
            row_in = flags.last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

`ifndef NO_ASSERTIONS
   // end of row wraps the column position
   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && flags.row_end |=> col_ff == '0)
      else $error("column position not cleared after end of row");
`endif

endmodule

`default_nettype wire

// ----- sv/hsv_tcp_queue.sv -----
// ---------------------------------------------------------------------------
// hsv_tcp_queue
// short queue of classified pixels between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_tcp_queue #(
   parameter int COL_W = 10,
   parameter int DEPTH = hsv_tcp_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire hsv_tcp_pkg::item_flags_type   push_flags,
   input  wire logic [COL_W-1:0]              push_col,
   output logic                               full,
   input  wire logic                          pop,
   output logic                               head_valid,
   output hsv_tcp_pkg::item_flags_type        head_flags,
   output logic [COL_W-1:0]                   head_col
);
   import hsv_tcp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_flags_type   flags_ff [DEPTH];
   logic [COL_W-1:0] col_ff   [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_flags = flags_ff[rd_ptr_ff];
   assign head_col   = col_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         flags_ff[wr_ptr_ff] <= push_flags;
         col_ff[wr_ptr_ff]   <= push_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

// ----- sv/hsv_tcp_back.sv -----
// ---------------------------------------------------------------------------
// hsv_tcp_back
// column store read-modify-write, running peak and result register
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_tcp_back #(
   parameter int MAX_COLS = hsv_tcp_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = hsv_tcp_pkg::DEF_MAX_ROWS,
   parameter int COL_W    = $clog2(MAX_COLS)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire hsv_tcp_pkg::item_flags_type   head_flags,
   input  wire logic [COL_W-1:0]              head_col,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output hsv_tcp_pkg::result_type            rsp_data
);
   import hsv_tcp_pkg::*;

   localparam int COUNT_W = $clog2(MAX_ROWS + 1);

   logic [COUNT_W-1:0] column_mem [MAX_COLS];

   logic               s1_valid_ff;
   item_flags_type     s1_flags_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [COUNT_W-1:0] rd_data_ff;

   logic [COUNT_W-1:0] best_count_ff, best_count_in;
   logic [COL_W-1:0]   best_col_ff, best_col_in;

   logic               rsp_valid_ff;
   result_type         rsp_data_ff, rsp_data_in;

   logic               s1_adv;
   logic               fwd;
   logic               done;
   logic [COUNT_W-1:0] cnt;

   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop    = head_valid && (!s1_valid_ff || s1_adv);
   // entering pixel reads the column that the leaving one writes now
   assign fwd    = s1_adv && (s1_col_ff == head_col);
   assign cnt    = s1_flags_ff.first_row ? COUNT_W'(s1_flags_ff.pass)
                                         : rd_data_ff + COUNT_W'(s1_flags_ff.pass);
   assign done   = s1_flags_ff.row_end && s1_flags_ff.last_row;

   always_comb begin
      best_count_in = best_count_ff;
      best_col_in   = best_col_ff;
      if (s1_flags_ff.last_row) begin
         if (s1_col_ff == '0) begin
            best_count_in = cnt;
            best_col_in   = '0;
         end else if (cnt > best_count_ff) begin
            best_count_in = cnt;
            best_col_in   = s1_col_ff;
         end
      end
      rsp_data_in.mask_bit    = s1_flags_ff.pass;
      rsp_data_in.frame_done  = done;
      rsp_data_in.peak_column = done ? PEAK_COLUMN_W'(best_col_in) : '0;
      rsp_data_in.peak_count  = done ? PEAK_COUNT_W'(best_count_in) : '0;
   end

   // column store and stage payload
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         column_mem[s1_col_ff] <= cnt;
         rsp_data_ff           <= rsp_data_in;
      end
      if (pop) begin
         s1_flags_ff <= head_flags;
         s1_col_ff   <= head_col;
         rd_data_ff  <= fwd ? cnt : column_mem[head_col];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         best_count_ff <= '0;
         best_col_ff   <= '0;
      end else begin
         if (pop) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff  <= 1'b1;
            best_count_ff <= best_count_in;
            best_col_ff   <= best_col_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_idle_peak_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_done |->
         rsp_data.peak_column == '0 && rsp_data.peak_count == '0)
      else $error("peak fields set outside end of frame");
   a_first_col_resets_best: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_flags_ff.last_row && s1_col_ff == '0 |=> best_col_ff == '0)
      else $error("running peak not restarted at first column of last row");
`endif

endmodule

`default_nettype wire

// ----- sv/hsv_threshold_column_peak_top.sv -----
// ---------------------------------------------------------------------------
// hsv_threshold_column_peak_top
// hsv colour threshold with per-column pass counts and peak column search
// ---------------------------------------------------------------------------
//
// channel   direction  payload       handshake
// req_      in         pixel_type    req_valid / req_stall
// rsp_      out        result_type   rsp_valid / rsp_stall
// csr_      in         11-bit data   csr_wr_en, index on csr_addr
//
// one pixel per clock sustained while rsp_stall stays low; each pixel does one
// read-modify-write of the column store, one read port and one write port,
// with forwarding when two adjacent pixels hit the same column
// a pixel passes through the queue, the stage-one register and the result
// register on its way to rsp_valid
// reset loads register defaults, clears positions and the running peak; no clearing pass,
// the first row of each frame writes the column store
// a stalled result backs up the queue, and req_stall rises when it is full
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_threshold_column_peak_top #(
   parameter int MAX_COLS    = hsv_tcp_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS    = hsv_tcp_pkg::DEF_MAX_ROWS,
   parameter int QUEUE_DEPTH = hsv_tcp_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration writes
   input  wire logic                                csr_wr_en,
   input  wire logic [hsv_tcp_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [hsv_tcp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // pixel transactions
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire hsv_tcp_pkg::pixel_type              req_data,
   // result transactions
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output hsv_tcp_pkg::result_type                  rsp_data
);
   import hsv_tcp_pkg::*;

   localparam int COL_W = $clog2(MAX_COLS);

   // front to queue
   logic             q_push;
   item_flags_type   q_push_flags;
   logic [COL_W-1:0] q_push_col;
   logic             q_full;

   // queue to back
   logic             q_pop;
   logic             q_head_valid;
   item_flags_type   q_head_flags;
   logic [COL_W-1:0] q_head_col;

   // range test and raster position
   hsv_tcp_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .COL_W    (COL_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_push_flags (q_push_flags),
      .q_push_col   (q_push_col)
   );

   // decouples the front from stalls in the result path
   hsv_tcp_queue #(
      .COL_W (COL_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_flags (q_push_flags),
      .push_col   (q_push_col),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_flags (q_head_flags),
      .head_col   (q_head_col)
   );

   // column counts, running peak and result register
   hsv_tcp_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .COL_W    (COL_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_flags (q_head_flags),
      .head_col   (q_head_col),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- bench/column_peak_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// column_peak_checker
// follows register writes and pixel transactions, works out the mask bit and
// the column peak of every frame, and compares each result transaction
// ---------------------------------------------------------------------------

module column_peak_checker #(
   parameter int MAX_COLS = hsv_tcp_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = hsv_tcp_pkg::DEF_MAX_ROWS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [hsv_tcp_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [hsv_tcp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  hsv_tcp_pkg::pixel_type              req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  hsv_tcp_pkg::result_type             rsp_data,
   output int                                  mismatches,
   output int                                  pending
);

   import hsv_tcp_pkg::*;

   localparam int REG_COUNT = 8;

   logic [CSR_DATA_W-1:0]    reg_file [REG_COUNT];
   logic [PEAK_COUNT_W-1:0]  column_tally [MAX_COLS];
   int unsigned              col_pos;
   int unsigned              row_pos;
   logic [PEAK_COUNT_W-1:0]  best_tally;
   logic [PEAK_COLUMN_W-1:0] best_col;
   result_type               awaited_results [$];
   int                       fail_count = 0;
   int                       result_index = 0;

   function automatic int unsigned clamp_geometry(input logic [GEOM_W-1:0] v,
                                                   input int unsigned limit);
      if (v == 0)
         return 1;
      if (v > limit)
         return limit;
      return v;
   endfunction

   function automatic logic in_window(input int unsigned x, input int unsigned lo,
                                      input int unsigned hi);
      return (lo <= x) && (x <= hi);
   endfunction

   // one pixel: threshold, column tally update, running peak on the last row
   function automatic result_type advance_column_peak(input pixel_type px);
      int unsigned             width;
      int unsigned             height;
      int unsigned             col;
      logic                    pass;
      logic                    row_end;
      logic                    last_row;
      logic [PEAK_COUNT_W-1:0] tally;
      result_type              r;
      width  = clamp_geometry(reg_file[CSR_FRAME_WIDTH], MAX_COLS);
      height = clamp_geometry(reg_file[CSR_FRAME_HEIGHT], MAX_ROWS);
      pass = in_window(px.hue, reg_file[CSR_HUE_LOW], reg_file[CSR_HUE_HIGH]) &&
             in_window(px.saturation, reg_file[CSR_SAT_LOW], reg_file[CSR_SAT_HIGH]) &&
             in_window(px.brightness, reg_file[CSR_VAL_LOW], reg_file[CSR_VAL_HIGH]);
      col = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
      // first row overwrites, later rows accumulate
      if (row_pos == 0)
         tally = PEAK_COUNT_W'(pass);
      else
         tally = column_tally[col] + PEAK_COUNT_W'(pass);
      column_tally[col] = tally;
      row_end  = (col_pos >= width - 1);
      last_row = (row_pos >= height - 1);
      if (last_row) begin
         if (col_pos == 0) begin
            best_tally = tally;
            best_col   = '0;
         end else if (tally > best_tally) begin
            best_tally = tally;
            best_col   = PEAK_COLUMN_W'(col_pos);
         end
      end
      r.mask_bit    = pass;
      r.frame_done  = row_end && last_row;
      r.peak_column = r.frame_done ? best_col : '0;
      r.peak_count  = r.frame_done ? best_tally : '0;
      if (row_end) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      result_type next_result;
      if (reset) begin
         reg_file[CSR_HUE_LOW]      = CSR_DATA_W'(RST_HUE_LOW);
         reg_file[CSR_HUE_HIGH]     = CSR_DATA_W'(RST_HUE_HIGH);
         reg_file[CSR_SAT_LOW]      = CSR_DATA_W'(RST_SAT_LOW);
         reg_file[CSR_SAT_HIGH]     = CSR_DATA_W'(RST_SAT_HIGH);
         reg_file[CSR_VAL_LOW]      = CSR_DATA_W'(RST_VAL_LOW);
         reg_file[CSR_VAL_HIGH]     = CSR_DATA_W'(RST_VAL_HIGH);
         reg_file[CSR_FRAME_WIDTH]  = RST_FRAME_WIDTH;
         reg_file[CSR_FRAME_HEIGHT] = RST_FRAME_HEIGHT;
         col_pos    = 0;
         row_pos    = 0;
         best_tally = '0;
         best_col   = '0;
         awaited_results.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_addr == CSR_FRAME_WIDTH || csr_addr == CSR_FRAME_HEIGHT)
               reg_file[csr_addr] = csr_wdata;
            else
               reg_file[csr_addr] = {{(CSR_DATA_W-CHAN_W){1'b0}}, csr_wdata[CHAN_W-1:0]};
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%t: result %0d arrived with nothing awaited", $realtime,
                           result_index);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.mask_bit !== want.mask_bit ||
                   rsp_data.frame_done !== want.frame_done ||
                   rsp_data.peak_column !== want.peak_column ||
                   rsp_data.peak_count !== want.peak_count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%t: result %0d expected mask %b done %b col %0d cnt %0d, got %b %b %0d %0d",
                              $realtime, result_index, want.mask_bit, want.frame_done,
                              want.peak_column, want.peak_count, rsp_data.mask_bit,
                              rsp_data.frame_done, rsp_data.peak_column, rsp_data.peak_count);
               end
            end
            result_index++;
         end
         if (req_valid && !req_stall) begin
            next_result = advance_column_peak(req_data);
            awaited_results.insert(awaited_results.size(), next_result);
         end
      end
      mismatches <= fail_count;
      pending    <= awaited_results.size();
   end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// drives pixel frames and register settings into the hsv threshold column
// peak block; the checker beside it predicts and compares every result
// ---------------------------------------------------------------------------

module tb;

   import hsv_tcp_pkg::*;

   localparam int HUE_MAX       = 180;
   localparam int CHAN_MAX      = 255;
   localparam int RANDOM_PIXELS = 800;
   // idling stops for the tail of the random part
   localparam int CALM_FROM     = 700;
   // settling margin after the last awaited result has arrived
   localparam int SETTLE_CYCLES = 8;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   pixel_type             req_data;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   result_type            rsp_data;
   int                    mismatches;
   int                    pending;

   // idling knobs, retuned per register setting
   int                    gap_pct = 0;
   int                    stall_pct = 0;
   int                    stall_left = 0;
   bit                    calm = 1'b0;

   int                    pixels_sent = 0;
   int                    settings_used = 0;
   int                    random_start;
   int                    w_pick;
   int                    h_pick;

   // current pass bands, used to aim random pixels near or inside them
   logic [CHAN_W-1:0]     band_lo [3];
   logic [CHAN_W-1:0]     band_hi [3];

   hsv_threshold_column_peak_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   column_peak_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side back-pressure: stall bursts of random length, started at random per stall_pct
   always @(posedge clock) begin
      if (reset || calm || stall_pct == 0) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // full register set; only called while the block is idle
   task automatic apply_settings(input logic [CSR_DATA_W-1:0] hl, hh, sl, sh, vl, vh,
                                 input logic [CSR_DATA_W-1:0] w, h);
      write_reg(CSR_HUE_LOW, hl);
      write_reg(CSR_HUE_HIGH, hh);
      write_reg(CSR_SAT_LOW, sl);
      write_reg(CSR_SAT_HIGH, sh);
      write_reg(CSR_VAL_LOW, vl);
      write_reg(CSR_VAL_HIGH, vh);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      csr_wr_en  <= 1'b0;
      band_lo[0] = hl[CHAN_W-1:0];
      band_hi[0] = hh[CHAN_W-1:0];
      band_lo[1] = sl[CHAN_W-1:0];
      band_hi[1] = sh[CHAN_W-1:0];
      band_lo[2] = vl[CHAN_W-1:0];
      band_hi[2] = vh[CHAN_W-1:0];
      settings_used++;
   endtask

   // one pixel transaction, with an optional idle burst in front of it
   task automatic send_pixel(input pixel_type px);
      if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   // wait for every awaited result, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CHAN_W-1:0] random_channel(input int k);
      int ceiling;
      int roll;
      ceiling = (k == 0) ? HUE_MAX : CHAN_MAX;
      roll    = $urandom_range(0, 99);
      if (band_lo[k] <= band_hi[k]) begin
         // band edges get extra weight
         if (roll < 8)
            return band_lo[k];
         if (roll < 16)
            return band_hi[k];
         if (roll < 65)
            return CHAN_W'($urandom_range(band_lo[k], band_hi[k]));
      end
      return CHAN_W'($urandom_range(0, ceiling));
   endfunction

   function automatic pixel_type random_pixel();
      return pixel_type'{random_channel(0), random_channel(1), random_channel(2)};
   endfunction

   // full, single-value, inverted or ordinary band for one channel
   function automatic void pick_band(input int k);
      int ceiling;
      int a;
      int b;
      ceiling = (k == 0) ? HUE_MAX : CHAN_MAX;
      a = $urandom_range(0, ceiling);
      b = $urandom_range(0, ceiling);
      case ($urandom_range(0, 7))
         0: begin
            band_lo[k] = '0;
            band_hi[k] = CHAN_W'(ceiling);
         end
         1: begin
            band_lo[k] = CHAN_W'(a);
            band_hi[k] = CHAN_W'(a);
         end
         2: begin
            a = $urandom_range(1, ceiling);
            band_lo[k] = CHAN_W'(a);
            band_hi[k] = CHAN_W'($urandom_range(0, a - 1));
         end
         default: begin
            band_lo[k] = CHAN_W'((a < b) ? a : b);
            band_hi[k] = CHAN_W'((a < b) ? b : a);
         end
      endcase
   endfunction

   task automatic send_frame(input int count);
      repeat (count) send_pixel(random_pixel());
   endtask

   initial begin
      reset     <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_addr  <= CSR_HUE_LOW;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // band edges on every channel, 4 x 2 frame; column 2 ends up the peak
      gap_pct   = 20;
      stall_pct = 20;
      apply_settings(20, 160, 1, 254, 1, 254, 4, 2);
      send_pixel(pixel_type'{8'd20, 8'd1, 8'd1});
      send_pixel(pixel_type'{8'd19, 8'd128, 8'd128});
      send_pixel(pixel_type'{8'd160, 8'd254, 8'd254});
      send_pixel(pixel_type'{8'd161, 8'd128, 8'd128});
      send_pixel(pixel_type'{8'd90, 8'd0, 8'd90});
      send_pixel(pixel_type'{8'd90, 8'd255, 8'd90});
      send_pixel(pixel_type'{8'd90, 8'd128, 8'd254});
      send_pixel(pixel_type'{8'd90, 8'd90, 8'd0});
      drain();

      // inverted hue band: nothing passes, column 0 with zero count
      apply_settings(100, 50, 0, 255, 0, 255, 1, 2);
      send_pixel(pixel_type'{8'd0, 8'd0, 8'd0});
      send_pixel(pixel_type'{8'd180, 8'd255, 8'd255});
      drain();

      // geometry shrunk mid-frame: column past the new width ends the row,
      // and the current row is already the last row under the new height
      apply_settings(0, 180, 0, 255, 0, 255, 4, 3);
      send_frame(6);
      drain();
      apply_settings(0, 180, 0, 255, 0, 255, 2, 2);
      send_pixel(random_pixel());
      drain();

      // oversized width must not end the row early; cutting the width
      // mid-row then ends the single-row frame
      gap_pct   = 5;
      stall_pct = 5;
      apply_settings(10, 170, 0, 255, 0, 255, 1026, 1);
      send_frame(5);
      drain();
      apply_settings(10, 170, 0, 255, 0, 255, 2, 1);
      send_pixel(random_pixel());
      drain();

      // oversized height cut short the same way, one column wide
      apply_settings(0, 180, 0, 255, 0, 255, 1, 1026);
      send_frame(5);
      drain();
      apply_settings(0, 180, 0, 255, 0, 255, 1, 2);
      send_pixel(random_pixel());
      drain();

      // zero width and height: every pixel is a whole frame
      apply_settings(0, 180, 0, 255, 0, 255, 0, 0);
      send_frame(3);
      drain();

      // random register settings, small frames, whole frames between writes
      random_start = pixels_sent;
      while (pixels_sent - random_start < RANDOM_PIXELS) begin
         calm      = (pixels_sent - random_start) >= CALM_FROM;
         gap_pct   = 5 * $urandom_range(0, 5);
         stall_pct = 5 * $urandom_range(0, 5);
         for (int k = 0; k < 3; k++)
            pick_band(k);
         w_pick = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
         h_pick = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
         apply_settings(CSR_DATA_W'(band_lo[0]), CSR_DATA_W'(band_hi[0]),
                        CSR_DATA_W'(band_lo[1]), CSR_DATA_W'(band_hi[1]),
                        CSR_DATA_W'(band_lo[2]), CSR_DATA_W'(band_hi[2]),
                        CSR_DATA_W'(w_pick), CSR_DATA_W'(h_pick));
         repeat ($urandom_range(1, 3))
            send_frame(((w_pick == 0) ? 1 : w_pick) * ((h_pick == 0) ? 1 : h_pick));
         drain();
      end

      $display("%0d pixel transactions under %0d register settings", pixels_sent,
               settings_used);
      $display("bands full, narrow, single-value and inverted; zero, small and oversized geometry");
      if (mismatches == 0 && pending == 0)
         $display("[hsv_threshold_column_peak_top] OK");
      else
         $display("[hsv_threshold_column_peak_top] ERROR");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("[hsv_threshold_column_peak_top] ERROR");
      $finish;
   end

endmodule

// ----- hsv_threshold_column_peak_top.f -----
sv/hsv_tcp_pkg.sv
sv/hsv_tcp_front.sv
sv/hsv_tcp_queue.sv
sv/hsv_tcp_back.sv
sv/hsv_threshold_column_peak_top.sv
bench/column_peak_checker.sv
bench/tb.sv
